// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/vcsa_pkg.sv =====
package vcsa_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_LOAD,
		ST_TRI
	} vcsa_state_t;

	localparam logic [31:0] LOAD_HIGH = 32'h0400_0010;
	localparam logic [31:0] LOAD_LOW  = 32'h0400_0000;
	localparam logic [31:0] TRI_HIGH  = 32'hbf00_0000;

	localparam int unsigned CORNERS     = 3;
	localparam logic [1:0]  CORNER_LAST = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TRI  = 1'b1;

	// slot * 10, cut to one byte
	function automatic logic [7:0] tri_byte(input logic [5:0] slot);
		logic [9:0] prod;
		prod = {4'b0, slot} * 10'd10;
		return prod[7:0];
	endfunction

endpackage

// ===== design/vertex_cache_slot_allocator.sv =====
// Channel   Dir  Fields (tdata / tuser from bit 0 up)
// s_axis    in   tdata: vertex_a, vertex_b, vertex_c, flush_cache
// m_axis    out  tdata: word_high, word_low; tuser: kind; tlast: last
//
// A triangle is accepted, then each of its three corners is looked up in turn through
// the shared slot comparator bank; the corners are then walked again to emit a load
// for each miss, and the triangle command closes the run. Results leave through one
// output register. Reset clears the slot valid bits, the sequencer and the output valid
// bit; slot contents stay undefined until written. A stalled output holds the sequencer
// at loads and the triangle command; s_axis_tready is low while a triangle is in work.
`include "assert_macros.svh"

module vertex_cache_slot_allocator #(
	parameter int CACHE_SLOTS = 16,
	parameter int INDEX_BITS  = 15,
	localparam int IN_W       = ((3 * INDEX_BITS + 1 + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	// vertex_a, vertex_b, vertex_c, flush_cache, zero pad
	input  logic [IN_W-1:0] s_axis_tdata,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// word_high, word_low
	output logic [63:0]     m_axis_tdata,
	// kind
	output logic [0:0]      m_axis_tuser,
	output logic            m_axis_tlast,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready
);

	import vcsa_pkg::*;

	localparam int SLOT_W = $clog2(CACHE_SLOTS);

	vcsa_state_t state_q, state_d;

	logic [1:0]             corner_q;
	logic [INDEX_BITS-1:0]  idx_q   [CORNERS];
	logic                   hit_q   [CORNERS];
	logic [SLOT_W-1:0]      slot_q  [CORNERS];
	logic [CACHE_SLOTS-1:0] locked_q;

	logic        out_valid_q;
	logic        out_kind_q;
	logic [31:0] out_high_q;
	logic [31:0] out_low_q;
	logic        out_last_q;

	logic                  in_acc;
	logic                  out_free;
	logic                  cur_hit;
	logic                  do_look;
	logic                  do_load;
	logic                  do_tri;
	logic                  advance;
	logic [SLOT_W-1:0]     free_slot;
	logic                  cam_hit;
	logic [SLOT_W-1:0]     cam_slot;
	logic [INDEX_BITS-1:0] cur_idx;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cur_hit  = hit_q[corner_q];
	assign cur_idx  = idx_q[corner_q];

	// lowest slot not locked by this triangle; top slot if none
	always_comb begin
		free_slot = SLOT_W'(CACHE_SLOTS - 1);
		for (int s = CACHE_SLOTS - 1; s >= 0; s--) begin
			if (!locked_q[s]) begin
				free_slot = SLOT_W'(s);
			end
		end
	end

	// shared comparator bank; also takes the slot writes of the load phase
	vcsa_slot_cam #(
		.CACHE_SLOTS (CACHE_SLOTS),
		.INDEX_BITS  (INDEX_BITS),
		.SLOT_W      (SLOT_W)
	) u_cam (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (in_acc && s_axis_tdata[3*INDEX_BITS]),
		.wr_en    (do_load),
		.wr_slot  (free_slot),
		.wr_index (cur_idx),
		.key      (cur_idx),
		.hit      (cam_hit),
		.hit_slot (cam_slot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if (corner_q == CORNER_LAST) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (corner_q == CORNER_LAST && advance) state_d = ST_TRI;
			end
			ST_TRI: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		do_look       = 1'b0;
		do_load       = 1'b0;
		do_tri        = 1'b0;
		advance       = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_LOOK: begin
				do_look = 1'b1;
				advance = 1'b1;
			end
			ST_LOAD: begin
				do_load = !cur_hit && out_free;
				advance = cur_hit || out_free;
			end
			ST_TRI:  do_tri = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			corner_q    <= '0;
			locked_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				locked_q <= '0;
				corner_q <= '0;
			end else if (advance) begin
				corner_q <= (corner_q == CORNER_LAST) ? 2'd0 : corner_q + 2'd1;
			end
			// lock hit slots during lookup, then each newly loaded slot
			if (do_look && cam_hit) begin
				locked_q[cam_slot] <= 1'b1;
			end else if (do_load) begin
				locked_q[free_slot] <= 1'b1;
			end
			if (do_load || do_tri) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q[0] <= s_axis_tdata[INDEX_BITS-1:0];
			idx_q[1] <= s_axis_tdata[2*INDEX_BITS-1:INDEX_BITS];
			idx_q[2] <= s_axis_tdata[3*INDEX_BITS-1:2*INDEX_BITS];
		end
		if (do_look) begin
			hit_q[corner_q]  <= cam_hit;
			slot_q[corner_q] <= cam_hit ? cam_slot : '0;
		end else if (do_load) begin
			slot_q[corner_q] <= free_slot;
		end
		if (do_load) begin
			out_kind_q <= KIND_LOAD;
			out_high_q <= LOAD_HIGH | (32'(free_slot) << 16);
			out_low_q  <= LOAD_LOW | (32'(cur_idx) << 4);
			out_last_q <= 1'b0;
		end else if (do_tri) begin
			out_kind_q <= KIND_TRI;
			out_high_q <= TRI_HIGH;
			out_low_q  <= {8'h00, tri_byte(6'(slot_q[0])), tri_byte(6'(slot_q[1])),
				tri_byte(6'(slot_q[2]))};
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_low_q, out_high_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	`ASSERT_SAME(a_last_on_tri, clk, arst_n, m_axis_tvalid, m_axis_tuser[0] == m_axis_tlast,
		"tlast does not mark the triangle command")
	`ASSERT_SAME(a_lock_bound, clk, arst_n, state_q != ST_IDLE, $countones(locked_q) <= 3,
		"more than three slots locked")
	`ASSERT_SAME(a_load_unlocked, clk, arst_n, do_load, !locked_q[free_slot],
		"load into a locked slot")
	`ASSERT_NEXT(a_accept_starts, clk, arst_n, in_acc,
		state_q == ST_LOOK && corner_q == 2'd0, "lookup did not start at first corner")

endmodule

// ===== design/vcsa_slot_cam.sv =====
`include "assert_macros.svh"

module vcsa_slot_cam #(
	parameter int CACHE_SLOTS = 16,
	parameter int INDEX_BITS  = 15,
	parameter int SLOT_W      = $clog2(CACHE_SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  wr_en,
	input  logic [SLOT_W-1:0]     wr_slot,
	input  logic [INDEX_BITS-1:0] wr_index,
	input  logic [INDEX_BITS-1:0] key,
	output logic                  hit,
	output logic [SLOT_W-1:0]     hit_slot
);

	logic [CACHE_SLOTS-1:0] valid_q;
	logic [INDEX_BITS-1:0]  vert_q [CACHE_SLOTS];
	logic [CACHE_SLOTS-1:0] match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vert_q[wr_slot] <= wr_index;
		end
	end

	// compare the key against every slot, lowest match wins
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int s = 0; s < CACHE_SLOTS; s++) begin
			match[s] = valid_q[s] && (vert_q[s] == key);
		end
		for (int s = CACHE_SLOTS - 1; s >= 0; s--) begin
			if (match[s]) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(s);
			end
		end
	end

	`ASSERT_NEXT(a_write_sets_valid, clk, arst_n, wr_en && !clear,
		valid_q[$past(wr_slot)], "written slot not valid")
	`ASSERT_SAME(a_hit_is_match, clk, arst_n, hit, match[hit_slot],
		"hit slot does not match key")
	`ASSERT_NEXT(a_clear_empties, clk, arst_n, clear, valid_q == '0,
		"slots still valid after clear")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// Drive triangle requests into the vertex cache allocator, predict the load and
// triangle commands each one causes, and check every command that leaves.
module tb_top;
	import vcsa_pkg::*;

	localparam int CACHE_DEPTH = 16;
	localparam int IDX_W       = 15;
	localparam int IN_W        = 48;

	// Random triangles after the directed ones, and the calm tail with no idling.
	localparam int RANDOM_TRIANGLES = 500;
	localparam int CALM_TAIL        = 60;

	// Long receiver hold-off that backs the block up into its input.
	localparam int HOLD_AFTER   = 150;
	localparam int HOLD_CYCLES  = 300;

	// Cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [IDX_W-1:0] vertex_a;
		logic [IDX_W-1:0] vertex_b;
		logic [IDX_W-1:0] vertex_c;
		logic             flush_cache;
	} triangle_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] word_high;
		logic [31:0] word_low;
		logic        last;
	} command_t;

	logic            clk;
	logic            arst_n = 1'b0;
	// vertex_a, vertex_b, vertex_c, flush_cache, zero pad
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	// word_high, word_low
	logic [63:0]     m_axis_tdata;
	// kind
	logic [0:0]      m_axis_tuser;
	logic            m_axis_tlast;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;

	vertex_cache_slot_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);

	// Shadow copy of the slot cache.
	logic [IDX_W-1:0] cache_vertex [CACHE_DEPTH];
	bit   [CACHE_DEPTH-1:0] cache_valid = '0;

	triangle_t pending_triangles[$];
	command_t  commands_due[$];
	triangle_t on_offer;

	int  total_triangles = 0;
	int  triangles_taken = 0;
	int  errors = 0;
	int  idle_cycles = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	logic [31:0] cycle_cnt = '0;

	wire calm       = triangles_taken >= total_triangles - CALM_TAIL;
	wire tx_idle_on = !calm && cycle_cnt[6];
	wire rx_idle_on = !calm && cycle_cnt[7];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [IN_W-1:0] pack_triangle(input triangle_t t);
		return {2'b00, t.flush_cache, t.vertex_c, t.vertex_b, t.vertex_a};
	endfunction

	// Work out the commands one triangle causes and advance the shadow cache.
	task automatic predict_commands(input triangle_t t);
		logic [IDX_W-1:0] idx [3];
		int               slot_of [3];
		bit               hit [3];
		bit [CACHE_DEPTH-1:0] locked;
		int               c;
		int               s;
		command_t         cmd;
		idx[0] = t.vertex_a;
		idx[1] = t.vertex_b;
		idx[2] = t.vertex_c;
		locked = '0;
		// A flush drops every slot before lookup.
		if (t.flush_cache)
			cache_valid = '0;
		// Lookup: lowest valid slot that holds the index wins, lock it.
		for (c = 0; c < 3; c++) begin
			hit[c] = 1'b0;
			slot_of[c] = 0;
			for (s = 0; s < CACHE_DEPTH; s++) begin
				if (!hit[c] && cache_valid[s] && cache_vertex[s] == idx[c]) begin
					hit[c] = 1'b1;
					slot_of[c] = s;
					locked[s] = 1'b1;
				end
			end
		end
		// Each miss takes the lowest unlocked slot; a repeated miss loads again.
		for (c = 0; c < 3; c++) begin
			if (!hit[c]) begin
				s = 0;
				while (s < CACHE_DEPTH && locked[s])
					s++;
				if (s >= CACHE_DEPTH)
					s = CACHE_DEPTH - 1;
				slot_of[c] = s;
				locked[s] = 1'b1;
				cache_vertex[s] = idx[c];
				cache_valid[s] = 1'b1;
				cmd.kind      = KIND_LOAD;
				cmd.word_high = LOAD_HIGH | (32'(s) << 16);
				cmd.word_low  = LOAD_LOW | (32'(idx[c]) << 4);
				cmd.last      = 1'b0;
				commands_due.push_back(cmd);
			end
		end
		// Triangle command closes the run with each slot times ten, one byte each.
		cmd.kind      = KIND_TRI;
		cmd.word_high = TRI_HIGH;
		cmd.word_low  = (((32'(slot_of[0]) * 10) & 32'hff) << 16) |
				(((32'(slot_of[1]) * 10) & 32'hff) << 8) |
				((32'(slot_of[2]) * 10) & 32'hff);
		cmd.last      = 1'b1;
		commands_due.push_back(cmd);
	endtask

	task automatic queue_triangle(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
			input logic [IDX_W-1:0] c, input logic f);
		triangle_t t;
		t.vertex_a = a;
		t.vertex_b = b;
		t.vertex_c = c;
		t.flush_cache = f;
		pending_triangles.push_back(t);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Stimulus: directed corners first, then random triangles biased toward hits.
	initial begin
		logic [IDX_W-1:0] recent[$];
		logic [IDX_W-1:0] corner [3];
		logic [IDX_W-1:0] v;
		triangle_t face;
		int n;
		int c;
		int r;

		// Extremes, all missing into an empty cache.
		queue_triangle(15'd0, 15'h7fff, 15'd1, 1'b1);
		// Same corners again: all hit.
		queue_triangle(15'd0, 15'h7fff, 15'd1, 1'b0);
		// Rotated order: hits map to other corners.
		queue_triangle(15'd1, 15'd0, 15'h7fff, 1'b0);
		// Flush with cached corners: all must load again.
		queue_triangle(15'd0, 15'h7fff, 15'd1, 1'b1);
		// Repeated miss on every corner.
		queue_triangle(15'd5, 15'd5, 15'd5, 1'b1);
		// Repeated vertex that hits, mixed with a miss.
		queue_triangle(15'd5, 15'd7, 15'd5, 1'b0);
		// Repeated miss on two corners next to a hit.
		queue_triangle(15'd9, 15'd7, 15'd9, 1'b0);
		// Alternating bit patterns across all corners.
		queue_triangle(15'h5555, 15'h2aaa, 15'h5555, 1'b0);
		queue_triangle(15'h2aaa, 15'h5555, 15'h2aaa, 1'b1);
		// All ones everywhere.
		queue_triangle(15'h7fff, 15'h7fff, 15'h7fff, 1'b1);
		// One hit, two fresh misses after a partial cache.
		queue_triangle(15'h7fff, 15'h1234, 15'h4321, 1'b0);
		queue_triangle(15'h4321, 15'h1234, 15'h0001, 1'b0);
		queue_triangle(15'd0, 15'd0, 15'h7fff, 1'b0);

		for (n = 0; n < RANDOM_TRIANGLES; n++) begin
			for (c = 0; c < 3; c++) begin
				r = $urandom_range(0, 99);
				if (r < 55 && recent.size() > 0)
					v = recent[$urandom_range(0, recent.size() - 1)];
				else if (r < 65 && c > 0)
					v = corner[$urandom_range(0, c - 1)];
				else
					v = 15'($urandom_range(0, 32767));
				corner[c] = v;
				recent.push_back(v);
				if (recent.size() > 8)
					void'(recent.pop_front());
			end
			face.vertex_a = corner[0];
			face.vertex_b = corner[1];
			face.vertex_c = corner[2];
			face.flush_cache = ($urandom_range(0, 99) < 8);
			pending_triangles.push_back(face);
		end
		total_triangles = pending_triangles.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request taken and every command seen, then idle a while.
		while (!(triangles_taken == total_triangles && commands_due.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && commands_due.size() == 0) begin
			$display("vertex_cache_slot_allocator regression: pass");
		end else begin
			$display("vertex_cache_slot_allocator regression: fail");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Sender: hold a request until taken, then predict it and offer the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				predict_commands(on_offer);
				triangles_taken <= triangles_taken + 1;
			end
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (tx_idle_on && $urandom_range(0, 7) == 0) begin
				// Start an idle gap of random length.
				tx_gap <= $urandom_range(0, 7);
				s_axis_tvalid <= 1'b0;
			end else if (pending_triangles.size() > 0) begin
				on_offer = pending_triangles.pop_front();
				s_axis_tdata <= pack_triangle(on_offer);
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off to back up the input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && triangles_taken >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
			rx_gap <= $urandom_range(0, 7);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: compare each accepted command with the oldest one due.
	always @(posedge clk) begin
		command_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (commands_due.size() == 0) begin
				$display("%0t: unexpected command, expected none actual kind %0d %h %h last %0d",
					$time, m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[63:32],
					m_axis_tlast);
				errors++;
			end else begin
				want = commands_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_axis_tuser[0]));
				check_field("word_high", want.word_high, m_axis_tdata[31:0]);
				check_field("word_low", want.word_low, m_axis_tdata[63:32]);
				check_field("last", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	// Watchdog: end the run if no handshake happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("vertex_cache_slot_allocator regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== vertex_cache_slot_allocator.f =====
+incdir+design
design/vcsa_pkg.sv
design/vcsa_slot_cam.sv
design/vertex_cache_slot_allocator.sv
bench/tb_top.sv
